// File: hw/rtl/pidc_pkg.sv
// Shared types, widths and register indexes for the two-mode PID controller.
package pidc_pkg;

    localparam int unsigned SAMPLE_W  = 16;
    localparam int unsigned ERR_W     = 17;
    localparam int unsigned DIFF1_W   = 18;
    localparam int unsigned DIFF2_W   = 19;
    localparam int unsigned SUM_W     = 31;
    localparam int unsigned RAW_SUM_W = 32;
    localparam int unsigned GAIN_W    = 16;
    localparam int unsigned ILIM_W    = 30;
    localparam int unsigned OLIM_W    = 15;
    localparam int unsigned ACC_W     = 50;
    localparam int unsigned FRAC_W    = 8;
    localparam int unsigned VAL_W     = ACC_W - FRAC_W;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DAT_W = 30;

    typedef logic signed [ERR_W-1:0]     err_t;
    typedef logic signed [DIFF1_W-1:0]   diff1_t;
    typedef logic signed [DIFF2_W-1:0]   diff2_t;
    typedef logic signed [SUM_W-1:0]     esum_t;
    typedef logic signed [RAW_SUM_W-1:0] raw_sum_t;
    typedef logic signed [ACC_W-1:0]     acc_t;
    typedef logic signed [VAL_W-1:0]     val_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MODE      = 3'd0,
        REG_GAIN_P    = 3'd1,
        REG_GAIN_I    = 3'd2,
        REG_GAIN_D    = 3'd3,
        REG_INT_LIMIT = 3'd4,
        REG_OUT_LIMIT = 3'd5
    } cfg_reg_t;

    localparam logic                MODE_INCREMENTAL = 1'b0;
    localparam logic                MODE_POSITIONAL  = 1'b1;
    localparam logic [OLIM_W-1:0]   OUT_LIMIT_RESET  = 15'h7FFF;
    localparam logic [ACC_W-1:0]    ROUND_HALF       = 50'd128;

endpackage

// File: hw/rtl/pid_controller_two_mode.sv
// Two-mode PID controller top level: input register, single-pass datapath, result register.
//
//  channel | direction | tdata / data                          | tuser
//  s_      | in        | [15:0] target, [31:16] measured       | -
//  m_      | out       | [15:0] drive                          | [0] clamped
//  cfg_    | in        | cfg_index = register, cfg_data [29:0] | -
//
//  One beat per cycle sustained while m_tready is high; a beat's result is registered once it advances.
//  The path from the input register through three multipliers, the sum, rounding
//  and clamp to the result register and controller state sets the clock.
//  aresetn is synchronous, active low; it resets config, controller state and both valids, not data.
//  A stalled result holds; the input register still takes one more beat meanwhile.
module pid_controller_two_mode (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [15:0] target, [31:16] measured
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] drive
    output logic        m_tuser,   // [0] clamped
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [pidc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [pidc_pkg::CFG_DAT_W-1:0] cfg_data
);

    logic                                   mode_reg;
    logic signed [pidc_pkg::GAIN_W-1:0]     gain_p_reg;
    logic signed [pidc_pkg::GAIN_W-1:0]     gain_i_reg;
    logic signed [pidc_pkg::GAIN_W-1:0]     gain_d_reg;
    logic [pidc_pkg::ILIM_W-1:0]            int_limit_reg;
    logic [pidc_pkg::OLIM_W-1:0]            out_limit_reg;

    logic                                   in_valid_reg;
    logic signed [pidc_pkg::SAMPLE_W-1:0]   target_reg;
    logic signed [pidc_pkg::SAMPLE_W-1:0]   measured_reg;
    logic                                   out_valid_reg;
    logic signed [pidc_pkg::SAMPLE_W-1:0]   drive_reg;
    logic                                   clamped_reg;

    pidc_pkg::err_t                         last_error_reg;
    pidc_pkg::err_t                         err_before_last_reg;
    pidc_pkg::esum_t                        error_sum_reg;
    logic signed [pidc_pkg::SAMPLE_W-1:0]   last_drive_reg;

    logic                                   advance;
    pidc_pkg::err_t                         err;
    pidc_pkg::diff1_t                       diff1;
    pidc_pkg::diff2_t                       diff2;
    pidc_pkg::raw_sum_t                     sum_raw;
    pidc_pkg::raw_sum_t                     int_lim_pos;
    pidc_pkg::raw_sum_t                     sum_clamped;
    pidc_pkg::esum_t                        error_sum_next;
    pidc_pkg::diff1_t                       op_p;
    pidc_pkg::esum_t                        op_i;
    pidc_pkg::diff2_t                       op_d;
    logic signed [pidc_pkg::GAIN_W+pidc_pkg::DIFF1_W-1:0] prod_p;
    logic signed [pidc_pkg::GAIN_W+pidc_pkg::SUM_W-1:0]   prod_i;
    logic signed [pidc_pkg::GAIN_W+pidc_pkg::DIFF2_W-1:0] prod_d;
    pidc_pkg::acc_t                         base;
    pidc_pkg::acc_t                         acc;
    pidc_pkg::acc_t                         acc_rnd;
    pidc_pkg::val_t                         val;
    pidc_pkg::val_t                         out_lim_pos;
    logic signed [pidc_pkg::SAMPLE_W-1:0]   drive_next;
    logic                                   clamped_next;

    assign cfg_ready = 1'b1;
    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = drive_reg;
    assign m_tuser   = clamped_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= pidc_pkg::MODE_INCREMENTAL;
            gain_p_reg    <= '0;
            gain_i_reg    <= '0;
            gain_d_reg    <= '0;
            int_limit_reg <= '0;
            out_limit_reg <= pidc_pkg::OUT_LIMIT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                pidc_pkg::REG_MODE:      mode_reg      <= cfg_data[0];
                pidc_pkg::REG_GAIN_P:    gain_p_reg    <= cfg_data[pidc_pkg::GAIN_W-1:0];
                pidc_pkg::REG_GAIN_I:    gain_i_reg    <= cfg_data[pidc_pkg::GAIN_W-1:0];
                pidc_pkg::REG_GAIN_D:    gain_d_reg    <= cfg_data[pidc_pkg::GAIN_W-1:0];
                pidc_pkg::REG_INT_LIMIT: int_limit_reg <= cfg_data[pidc_pkg::ILIM_W-1:0];
                pidc_pkg::REG_OUT_LIMIT: out_limit_reg <= cfg_data[pidc_pkg::OLIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        err = pidc_pkg::err_t'(target_reg) - pidc_pkg::err_t'(measured_reg);
        diff1 = pidc_pkg::diff1_t'(err) - pidc_pkg::diff1_t'(last_error_reg);
        diff2 = pidc_pkg::diff2_t'(err) - (pidc_pkg::diff2_t'(last_error_reg) <<< 1)
              + pidc_pkg::diff2_t'(err_before_last_reg);

        sum_raw     = pidc_pkg::raw_sum_t'(error_sum_reg) + pidc_pkg::raw_sum_t'(err);
        int_lim_pos = $signed({{(pidc_pkg::RAW_SUM_W-pidc_pkg::ILIM_W){1'b0}}, int_limit_reg});
        if (sum_raw > int_lim_pos) begin
            sum_clamped = int_lim_pos;
        end else if (sum_raw < -int_lim_pos) begin
            sum_clamped = -int_lim_pos;
        end else begin
            sum_clamped = sum_raw;
        end

        if (mode_reg == pidc_pkg::MODE_POSITIONAL) begin
            op_p           = pidc_pkg::diff1_t'(err);
            op_i           = sum_clamped[pidc_pkg::SUM_W-1:0];
            op_d           = pidc_pkg::diff2_t'(diff1);
            base           = '0;
            error_sum_next = sum_clamped[pidc_pkg::SUM_W-1:0];
        end else begin
            op_p           = diff1;
            op_i           = pidc_pkg::esum_t'(err);
            op_d           = diff2;
            base           = pidc_pkg::acc_t'(last_drive_reg) <<< pidc_pkg::FRAC_W;
            error_sum_next = pidc_pkg::esum_t'(err);
        end

        prod_p = gain_p_reg * op_p;
        prod_i = gain_i_reg * op_i;
        prod_d = gain_d_reg * op_d;

        acc = base + pidc_pkg::acc_t'(prod_p) + pidc_pkg::acc_t'(prod_i)
            + pidc_pkg::acc_t'(prod_d);
        acc_rnd = acc + $signed(pidc_pkg::ROUND_HALF);
        val     = acc_rnd[pidc_pkg::ACC_W-1:pidc_pkg::FRAC_W];

        out_lim_pos = $signed({{(pidc_pkg::VAL_W-pidc_pkg::OLIM_W){1'b0}}, out_limit_reg});
        if (val > out_lim_pos) begin
            drive_next   = out_lim_pos[pidc_pkg::SAMPLE_W-1:0];
            clamped_next = 1'b1;
        end else if (val < -out_lim_pos) begin
            drive_next   = pidc_pkg::SAMPLE_W'(-out_lim_pos);
            clamped_next = 1'b1;
        end else begin
            drive_next   = val[pidc_pkg::SAMPLE_W-1:0];
            clamped_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg        <= 1'b0;
            out_valid_reg       <= 1'b0;
            last_error_reg      <= '0;
            err_before_last_reg <= '0;
            error_sum_reg       <= '0;
            last_drive_reg      <= '0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg  <= 1'b1;
                last_error_reg <= err;
                error_sum_reg  <= error_sum_next;
                if (mode_reg == pidc_pkg::MODE_INCREMENTAL) begin
                    err_before_last_reg <= last_error_reg;
                    last_drive_reg      <= drive_next;
                end
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            target_reg   <= s_tdata[15:0];
            measured_reg <= s_tdata[31:16];
        end
        if (advance) begin
            drive_reg   <= drive_next;
            clamped_reg <= clamped_next;
        end
    end

`ifndef ASSERT_OFF
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !in_valid_reg && !out_valid_reg)
        else $error("valids not cleared by reset");

    a_advance_fills_out: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> out_valid_reg)
        else $error("result register empty after advance");

    a_clamp_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> !clamped_reg
            || drive_reg == $signed({1'b0, $past(out_limit_reg)})
            || drive_reg == -$signed({1'b0, $past(out_limit_reg)}))
        else $error("clamped flag without drive at limit");

    a_incr_last_drive: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && mode_reg == pidc_pkg::MODE_INCREMENTAL |=> last_drive_reg == drive_reg)
        else $error("last drive does not track result");

    a_int_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && mode_reg == pidc_pkg::MODE_POSITIONAL |=>
            error_sum_reg <= $signed({1'b0, $past(int_limit_reg)})
            && error_sum_reg >= -$signed({1'b0, $past(int_limit_reg)}))
        else $error("error sum outside integral limit");
`endif

endmodule
